/* sv/ietlv_pkg.sv */
// ----------------------------------------------------------------------------
// ietlv_pkg
// Shared types and constants for the information-element TLV walker.
// ----------------------------------------------------------------------------
package ietlv_pkg;

    // default walk limit in bytes
    localparam int unsigned IETLV_MAX_BLOB_BYTES = 4096;

    // fixed field widths of the stream payloads
    localparam int unsigned IETLV_BYTE_W     = 8;
    localparam int unsigned IETLV_STATUS_W   = 2;
    localparam int unsigned IETLV_CONSUMED_W = 13;
    localparam int unsigned IETLV_OFFSET_W   = 12;
    localparam int unsigned IETLV_LENGTH_W   = 8;
    localparam int unsigned IETLV_OUT_W      = 40;

    // walk phase
    typedef enum logic [1:0] {
        PH_ID,
        PH_LEN,
        PH_BODY
    } t_phase;

    // walk status codes
    typedef enum logic [IETLV_STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_STRAY     = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    // result transaction, first field in the highest bits
    typedef struct packed {
        logic [3:0]                  pad;
        logic [IETLV_LENGTH_W-1:0]   found_length;
        logic [IETLV_OFFSET_W-1:0]   found_offset;
        logic                        found;
        logic [IETLV_CONSUMED_W-1:0] consumed_size;
        t_status                     walk_status;
    } t_result;

endpackage

/* sv/wlan_ie_tlv_walker.sv */
// ----------------------------------------------------------------------------
// wlan_ie_tlv_walker
// Walks an 802.11 information-element blob one byte per transaction and
// reports status, well-formed size and the first element matching an id.
// ----------------------------------------------------------------------------
// The blob arrives one byte per transaction on the slave stream, tlast on its
// final byte; one result transaction follows each tlast. Bytes are taken one
// per cycle, back to back: each byte passes an input register and a single
// small phase update into the result register, and a waiting result only
// stalls the input once a second tlast reaches the update stage. Bytes beyond
// MAX_BLOB_BYTES are ignored and flag status 3. The user must write the
// target id on the cfg channel between blobs (unenforced); it is compared as
// each element completes. After a result the walk state starts clean.
module wlan_ie_tlv_walker
    import ietlv_pkg::*;
#(
    parameter int unsigned MAX_BLOB_BYTES = IETLV_MAX_BLOB_BYTES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration: target_id
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IETLV_BYTE_W-1:0] i_cfg_data,
    // blob byte stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IETLV_BYTE_W-1:0] s_axis_tdata,   // [7:0] blob_byte
    input  logic                    s_axis_tlast,   // last_byte
    // result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [1:0] walk_status, [14:2] consumed_size, [15] found,
    // [27:16] found_offset, [35:28] found_length, [39:36] zero
    output logic [IETLV_OUT_W-1:0]  m_axis_tdata
);

    localparam int unsigned PW = $clog2(MAX_BLOB_BYTES + 1);
    localparam int unsigned SW = PW + 1;
    localparam int unsigned CW = (SW > IETLV_CONSUMED_W) ? SW : IETLV_CONSUMED_W;
    localparam int unsigned OW = (SW > IETLV_OFFSET_W) ? SW : IETLV_OFFSET_W;
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_BLOB_BYTES);

    // configuration register
    logic [IETLV_BYTE_W-1:0] r_target_id;

    // input register
    logic                    r_in_valid;
    logic [IETLV_BYTE_W-1:0] r_in_byte;
    logic                    r_in_last;

    // walk state
    t_phase                    r_phase, n_phase;
    logic [IETLV_BYTE_W-1:0]   r_body_left, n_body_left;
    logic [IETLV_BYTE_W-1:0]   r_cur_id, n_cur_id;
    logic [IETLV_LENGTH_W-1:0] r_cur_len, n_cur_len;
    logic [PW-1:0]             r_pos, n_pos;
    logic [PW-1:0]             r_start, n_start;
    logic                      r_stopped, n_stopped;
    logic                      r_match, n_match;
    logic [IETLV_OFFSET_W-1:0] r_match_off, n_match_off;
    logic [IETLV_LENGTH_W-1:0] r_match_len, n_match_len;

    // result register
    logic    r_out_valid;
    t_result r_out, n_out;

    logic          advance;
    logic          done;
    logic [SW-1:0] hdr_end;
    logic [CW-1:0] consumed;
    logic [OW-1:0] offset_ext;

    // the update stage moves unless a result would overwrite a waiting one
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= '0;
        end else if (i_cfg_valid) begin
            r_target_id <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // walk state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_body_left <= '0;
            r_cur_id    <= '0;
            r_cur_len   <= '0;
            r_pos       <= '0;
            r_start     <= '0;
            r_stopped   <= 1'b0;
            r_match     <= 1'b0;
            r_match_off <= '0;
            r_match_len <= '0;
        end else begin
            r_phase     <= n_phase;
            r_body_left <= n_body_left;
            r_cur_id    <= n_cur_id;
            r_cur_len   <= n_cur_len;
            r_pos       <= n_pos;
            r_start     <= n_start;
            r_stopped   <= n_stopped;
            r_match     <= n_match;
            r_match_off <= n_match_off;
            r_match_len <= n_match_len;
        end
    end

    assign hdr_end    = SW'(r_start) + SW'(2);
    assign offset_ext = OW'(hdr_end);

    // phase update and result assembly
    always_comb begin
        n_phase     = r_phase;
        n_body_left = r_body_left;
        n_cur_id    = r_cur_id;
        n_cur_len   = r_cur_len;
        n_pos       = r_pos;
        n_start     = r_start;
        n_stopped   = r_stopped;
        n_match     = r_match;
        n_match_off = r_match_off;
        n_match_len = r_match_len;
        done        = 1'b0;
        consumed    = '0;
        n_out       = r_out;

        if (advance) begin
            if (r_pos >= MAX_POS) begin
                n_stopped = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_ID: begin
                        n_cur_id = r_in_byte;
                        n_start  = r_pos;
                        n_phase  = PH_LEN;
                    end
                    PH_LEN: begin
                        n_cur_len = r_in_byte;
                        if (r_in_byte == '0) begin
                            done = 1'b1;
                        end else begin
                            n_body_left = r_in_byte;
                            n_phase     = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_body_left = r_body_left - 1'b1;
                        done        = (r_body_left == IETLV_BYTE_W'(1));
                    end
                    default: begin
                        n_phase = PH_ID;
                    end
                endcase
                n_pos = r_pos + 1'b1;
            end

            // element complete: remember the first match
            if (done) begin
                n_phase = PH_ID;
                if (!r_match && r_cur_id == r_target_id) begin
                    n_match     = 1'b1;
                    n_match_off = offset_ext[IETLV_OFFSET_W-1:0];
                    n_match_len = n_cur_len;
                end
            end

            // end of blob: status and consumed size from the ending phase, status 3 if
            // stopped, the match fields, then clear the walk
            if (r_in_last) begin
                unique case (n_phase)
                    PH_ID: begin
                        n_out.walk_status = ST_OK;
                        consumed          = CW'(n_pos);
                    end
                    PH_LEN: begin
                        n_out.walk_status = ST_STRAY;
                        consumed          = CW'(n_start);
                    end
                    default: begin
                        n_out.walk_status = ST_TRUNCATED;
                        consumed          = CW'(n_start) + CW'(2);
                    end
                endcase
                if (n_stopped) begin
                    n_out.walk_status = ST_TOO_LONG;
                end
                n_out.pad           = '0;
                n_out.consumed_size = consumed[IETLV_CONSUMED_W-1:0];
                n_out.found         = n_match;
                n_out.found_offset  = n_match ? n_match_off : '0;
                n_out.found_length  = n_match ? n_match_len : '0;

                n_phase     = PH_ID;
                n_body_left = '0;
                n_cur_id    = '0;
                n_cur_len   = '0;
                n_pos       = '0;
                n_start     = '0;
                n_stopped   = 1'b0;
                n_match     = 1'b0;
                n_match_off = '0;
                n_match_len = '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

/* sv/ietlv_checker.sv */
// ----------------------------------------------------------------------------
// ietlv_checker
// Port-level checks on the TLV walker's result stream.
// ----------------------------------------------------------------------------
module ietlv_checker
    import ietlv_pkg::*;
#(
    parameter int unsigned MAX_BLOB_BYTES = IETLV_MAX_BLOB_BYTES
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [IETLV_OUT_W-1:0] m_axis_tdata
);

    t_result res;
    assign res = m_axis_tdata;

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // no match means zero offset and length
    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.found |-> res.found_offset == '0 && res.found_length == '0)
        else $error("match fields set without a match");

    // walk never reports more than the limit (checked for limits below 8192)
    a_consumed_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (MAX_BLOB_BYTES < 8192) |->
            32'(res.consumed_size) <= MAX_BLOB_BYTES)
        else $error("consumed size beyond the blob limit");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res.pad == '0)
        else $error("result pad bits not zero");

endmodule

bind wlan_ie_tlv_walker ietlv_checker #(
    .MAX_BLOB_BYTES(MAX_BLOB_BYTES)
) u_ietlv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/wlan_ie_tlv_walker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlan_ie_tlv_walker_test
// Streams information-element blobs into the walker, byte by byte, and checks
// every walk report against a behavioral model kept in a scoreboard class.
// Covers hand-picked blobs, random blobs under several target ids, random
// idling on both streams and a long result hold-off.
// ----------------------------------------------------------------------------
module wlan_ie_tlv_walker_test;
    import ietlv_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 150;

    // walk model and expected report store
    class ie_walk_checker;
        logic [7:0]  target;
        t_phase      phase;
        logic [7:0]  body_cnt;
        logic [7:0]  elem_id;
        logic [7:0]  elem_len;
        int unsigned pos;
        int unsigned elem_start;
        bit          overflowed;
        bit          hit;
        int unsigned hit_offset;
        logic [7:0]  hit_len;
        t_result     expected_reports[$];
        int unsigned errors;

        function new();
            target = '0;
            errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            phase      = PH_ID;
            body_cnt   = '0;
            elem_id    = '0;
            elem_len   = '0;
            pos        = 0;
            elem_start = 0;
            overflowed = 1'b0;
            hit        = 1'b0;
            hit_offset = 0;
            hit_len    = '0;
        endfunction

        // first complete element with the target id wins
        function void close_element();
            if (!hit && elem_id == target) begin
                hit        = 1'b1;
                hit_offset = elem_start + 2;
                hit_len    = elem_len;
            end
            phase = PH_ID;
        endfunction

        function void set_target(logic [7:0] v);
            target = v;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // called for every accepted input byte
        function void predict_byte(logic [7:0] b, logic last);
            t_result     r;
            t_status     st;
            int unsigned cons;
            if (pos >= IETLV_MAX_BLOB_BYTES) begin
                overflowed = 1'b1;
            end else begin
                case (phase)
                    PH_ID: begin
                        elem_id    = b;
                        elem_start = pos;
                        phase      = PH_LEN;
                    end
                    PH_LEN: begin
                        elem_len = b;
                        if (b == 8'd0) begin
                            close_element();
                        end else begin
                            body_cnt = b;
                            phase    = PH_BODY;
                        end
                    end
                    default: begin
                        body_cnt = body_cnt - 8'd1;
                        if (body_cnt == 8'd0)
                            close_element();
                    end
                endcase
                pos++;
            end
            if (!last)
                return;
            // report on the marked byte
            case (phase)
                PH_ID: begin
                    st   = ST_OK;
                    cons = pos;
                end
                PH_LEN: begin
                    st   = ST_STRAY;
                    cons = elem_start;
                end
                default: begin
                    st   = ST_TRUNCATED;
                    cons = elem_start + 2;
                end
            endcase
            if (overflowed)
                st = ST_TOO_LONG;
            r.pad           = '0;
            r.walk_status   = st;
            r.consumed_size = 13'(cons);
            r.found         = hit;
            r.found_offset  = hit ? 12'(hit_offset) : 12'd0;
            r.found_length  = hit ? hit_len : 8'd0;
            expected_reports.push_back(r);
            clear_walk();
        endfunction

        // called for every accepted result transaction
        function void check_result(t_result got);
            t_result exp;
            if (expected_reports.size() == 0) begin
                $error("result transaction with no report expected: %h", got);
                errors++;
                return;
            end
            exp = expected_reports.pop_front();
            if (got.walk_status !== exp.walk_status) begin
                $error("walk_status: expected %0d, actual %0d",
                       exp.walk_status, got.walk_status);
                errors++;
            end
            if (got.consumed_size !== exp.consumed_size) begin
                $error("consumed_size: expected %0d, actual %0d",
                       exp.consumed_size, got.consumed_size);
                errors++;
            end
            if (got.found !== exp.found) begin
                $error("found: expected %0d, actual %0d", exp.found, got.found);
                errors++;
            end
            if (got.found_offset !== exp.found_offset) begin
                $error("found_offset: expected %0d, actual %0d",
                       exp.found_offset, got.found_offset);
                errors++;
            end
            if (got.found_length !== exp.found_length) begin
                $error("found_length: expected %0d, actual %0d",
                       exp.found_length, got.found_length);
                errors++;
            end
            if (got.pad !== exp.pad) begin
                $error("pad: expected %0d, actual %0d", exp.pad, got.pad);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [7:0]             i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // [7:0] blob_byte
    logic                   s_axis_tlast = 1'b0; // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] walk_status, [14:2] consumed_size, [15] found,
    // [27:16] found_offset, [35:28] found_length, [39:36] zero
    logic [IETLV_OUT_W-1:0] m_axis_tdata;

    ie_walk_checker walk_sb = new();
    bit             idle_on = 1'b1;
    bit             hold_req = 1'b0;
    int unsigned    hold_left = 0;
    int unsigned    stall_cycles = 0;
    logic [7:0]     cur_target = '0;

    wlan_ie_tlv_walker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each transaction, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            walk_sb.check_result(t_result'(m_axis_tdata));
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 14);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        walk_sb.predict_byte(b, last);
    endtask

    task automatic send_blob(input t_byte_q blob);
        foreach (blob[i])
            send_byte(blob[i], i == blob.size() - 1);
    endtask

    // stop offering and let every report come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (walk_sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        walk_sb.set_target(v);
        cur_target = v;
    endtask

    // mostly well-formed element chains, with broken tails and plain noise
    task automatic make_random_blob(output t_byte_q blob, input bit short_only);
        int n_el;
        int len;
        int kind;
        blob = {};
        n_el = $urandom_range(1, 4);
        repeat (n_el) begin
            blob.push_back(($urandom_range(0, 99) < 30) ? cur_target
                                                         : 8'($urandom_range(0, 255)));
            if (short_only)
                len = $urandom_range(0, 3);
            else if ($urandom_range(0, 99) < 3)
                len = $urandom_range(200, 255);
            else
                len = $urandom_range(0, 24);
            blob.push_back(8'(len));
            repeat (len) blob.push_back(8'($urandom_range(0, 255)));
        end
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            // header complete, body cut short
            blob.push_back(($urandom_range(0, 1) == 1) ? cur_target
                                                        : 8'($urandom_range(0, 255)));
            len = short_only ? $urandom_range(1, 3) : $urandom_range(1, 30);
            blob.push_back(8'(len));
            repeat ($urandom_range(0, len - 1)) blob.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 22) begin
            // lone id byte at the end
            blob.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 32) begin
            blob = {};
            repeat ($urandom_range(1, short_only ? 4 : 16))
                blob.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // main sequence
    initial begin
        t_byte_q     blob;
        int          sent;
        logic [7:0]  phase_targets[5];

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_target(8'd0);

        // directed blobs under the SSID id
        send_blob('{8'd0, 8'd0});                       // zero-length match
        send_blob('{8'd221, 8'd1, 8'hFF});              // no match
        send_blob('{8'd0, 8'd2, 8'hAA, 8'h55, 8'd48, 8'd255}); // truncated body
        send_blob('{8'd5, 8'd0, 8'd7});                 // stray trailing byte
        send_blob('{8'd9});                             // single id byte
        send_blob('{8'd255, 8'd1});                     // header only
        send_blob('{8'd0, 8'd3, 8'd1, 8'd2, 8'd3, 8'd0, 8'd1, 8'd9}); // first match only
        drain();

        // random phases over several target ids
        phase_targets = '{8'd255, 8'($urandom_range(1, 254)), 8'd221, 8'd0,
                          8'($urandom_range(0, 255))};
        foreach (phase_targets[k]) begin
            write_target(phase_targets[k]);
            idle_on = (k != 2);
            if (k == 3) begin
                // hold results back while short blobs keep coming
                hold_req = 1'b1;
                repeat (10) begin
                    make_random_blob(blob, 1'b1);
                    send_blob(blob);
                end
            end
            sent = 0;
            while (sent < 50) begin
                make_random_blob(blob, 1'b0);
                send_blob(blob);
                sent += blob.size();
            end
            drain();
        end
        idle_on = 1'b1;

        // walk under a new target id right after the random phases
        write_target(8'h30);
        send_blob('{8'h30, 8'd2, 8'h01, 8'h02});
        drain();
        repeat (10) @(posedge i_clk);

        if (walk_sb.errors == 0 && walk_sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* wlan_ie_tlv_walker.f */
sv/ietlv_pkg.sv
sv/wlan_ie_tlv_walker.sv
sv/ietlv_checker.sv
bench/wlan_ie_tlv_walker_test.sv
